// ===== hdl/brlm_pkg.sv =====
package brlm_pkg;

    localparam int SAMPLE_W = 16;
    localparam int COEFF_W  = 32;
    localparam int DELAY_W  = 40;
    localparam int SUM_W    = 64;
    localparam int LEVEL_W  = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_FEED0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FEED1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FEED2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BACK1  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BACK2  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 3'd5;

    localparam logic signed [COEFF_W-1:0] FEED0_RST = 32'sd1073741824;
    localparam logic signed [COEFF_W-1:0] FEED1_RST = 32'h8000_0000;
    localparam logic signed [COEFF_W-1:0] FEED2_RST = 32'sd1073741824;
    localparam logic signed [COEFF_W-1:0] BACK1_RST = -32'sd2136797184;
    localparam logic signed [COEFF_W-1:0] BACK2_RST = 32'sd1063081984;

    localparam logic signed [31:0] DB_PER_LOG2 = 32'sd101008905;

    // window-end request handed from the filter front to the level back end
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [24:0]      count;
        logic             calibrate;
    } win_req_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] rms_level;
        logic [LEVEL_W-1:0] level_db;
        logic [LEVEL_W-1:0] level_db_spl;
        logic               calibration_done;
    } result_t;

endpackage

// ===== hdl/brlm_if.sv =====
interface brlm_sample_if;
    logic        valid;
    logic        ready;
    logic [15:0] sample;
    logic        block_start;
    logic        window_last;
    logic        calibrate;
    modport source (output valid, sample, block_start, window_last, calibrate, input ready);
    modport sink (input valid, sample, block_start, window_last, calibrate, output ready);
endinterface

interface brlm_result_if;
    logic        valid;
    logic        ready;
    logic [15:0] rms_level;
    logic [15:0] level_db;
    logic [15:0] level_db_spl;
    logic        calibration_done;
    modport source (output valid, rms_level, level_db, level_db_spl, calibration_done,
                    input ready);
    modport sink (input valid, rms_level, level_db, level_db_spl, calibration_done,
                  output ready);
endinterface

interface brlm_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/brlm_front.sv =====
module brlm_front #(
    parameter int MAX_WINDOW_SAMPLES = 1048576
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [15:0]               sample,
    input  logic                             block_start,
    input  logic                             window_last,
    input  logic                             calibrate,
    input  logic signed [31:0]               feed0,
    input  logic signed [31:0]               feed1,
    input  logic signed [31:0]               feed2,
    input  logic signed [31:0]               back1,
    input  logic signed [31:0]               back2,
    output logic                             req_valid,
    input  logic                             req_ready,
    output brlm_pkg::win_req_t               req
);
    import brlm_pkg::*;

    localparam int CNT_W = $clog2(MAX_WINDOW_SAMPLES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_WINDOW_SAMPLES);
    localparam logic signed [DELAY_W+1:0] SAT_HI = (42'sd1 <<< 39) - 42'sd1;
    localparam logic signed [DELAY_W+1:0] SAT_LO = -(42'sd1 <<< 39);

    typedef enum logic [1:0] {
        ST_FF = 2'b01,
        ST_FB = 2'b10
    } fstate_t;

    fstate_t state_reg, state_next;
    logic signed [DELAY_W-1:0] d1_reg, d1_next, d2_reg, d2_next;
    logic signed [DELAY_W-1:0] y_reg, y_next;
    logic signed [DELAY_W+1:0] p1_reg, p1_next;
    logic signed [DELAY_W-1:0] p2_reg, p2_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic last_reg, last_next, cal_reg, cal_next;
    logic pend_reg, pend_next;

    logic signed [47:0] m0, m1, m2;
    logic signed [63:0] ma1, ma2;
    logic signed [DELAY_W-1:0] yf;
    logic signed [DELAY_W-1:0] d1_use;
    logic signed [24:0] y15;
    logic [24:0] yabs;
    logic [49:0] sq;
    logic [SUM_W:0] sum_add;

    function automatic logic signed [DELAY_W-1:0] sat40(input logic signed [DELAY_W+1:0] v);
        if (v > SAT_HI) return SAT_HI[DELAY_W-1:0];
        if (v < SAT_LO) return SAT_LO[DELAY_W-1:0];
        return v[DELAY_W-1:0];
    endfunction

    assign d1_use = block_start ? '0 : d1_reg;
    assign m0 = 48'(feed0 * sample);
    assign m1 = 48'(feed1 * sample);
    assign m2 = 48'(feed2 * sample);
    assign yf = y_reg >>> 8;
    assign ma1 = 64'(back1 * $signed(yf[31:0]));
    assign ma2 = 64'(back2 * $signed(yf[31:0]));
    assign y15 = 25'(y_reg >>> 15);
    assign yabs = y15[24] ? 25'(-y15) : 25'(y15);
    assign sq = 50'(yabs) * 50'(yabs);
    assign sum_add = {1'b0, sum_reg} + 65'(sq);

    assign in_ready = (state_reg == ST_FF) && !pend_reg;
    assign req_valid = pend_reg;
    assign req.sum = sum_reg;
    assign req.count = 25'(cnt_reg);
    assign req.calibrate = cal_reg;

    always_comb
    begin
        state_next = state_reg;
        d1_next = d1_reg;
        d2_next = d2_reg;
        y_next = y_reg;
        p1_next = p1_reg;
        p2_next = p2_reg;
        sum_next = sum_reg;
        cnt_next = cnt_reg;
        last_next = last_reg;
        cal_next = cal_reg;
        pend_next = pend_reg;
        if (pend_reg && req_ready)
        begin
            pend_next = 1'b0;
            sum_next = '0;
            cnt_next = '0;
        end
        case (state_reg)
            ST_FF:
            begin
                if (in_valid && in_ready)
                begin
                    y_next = sat40(42'(m0 >>> 15) + 42'(d1_use));
                    p1_next = 42'(m1 >>> 15) + 42'(block_start ? 40'sd0 : d2_reg);
                    p2_next = 40'(m2 >>> 15);
                    last_next = window_last;
                    cal_next = calibrate;
                    state_next = ST_FB;
                end
            end
            ST_FB:
            begin
                // p1 holds b1*x>>15 + d2, at most 2^39+2^31, kept in 42 bits
                d1_next = sat40(p1_reg - 42'(ma1 >>> 22));
                d2_next = sat40(42'(p2_reg) - 42'(ma2 >>> 22));
                if (cnt_reg < CNT_MAX)
                begin
                    sum_next = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
                    cnt_next = cnt_reg + 1'b1;
                end
                if (last_reg)
                    pend_next = 1'b1;
                state_next = ST_FF;
            end
            default: state_next = ST_FF;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_FF;
            d1_reg <= '0;
            d2_reg <= '0;
            sum_reg <= '0;
            cnt_reg <= '0;
            pend_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            d1_reg <= d1_next;
            d2_reg <= d2_next;
            sum_reg <= sum_next;
            cnt_reg <= cnt_next;
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        y_reg <= y_next;
        p1_reg <= p1_next;
        p2_reg <= p2_next;
        last_reg <= last_next;
        cal_reg <= cal_next;
    end

endmodule

// ===== hdl/brlm_back.sv =====
module brlm_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  brlm_pkg::win_req_t  req,
    input  logic signed [15:0]  spl_offset,
    output logic                res_valid,
    input  logic                res_ready,
    output brlm_pkg::result_t   res
);
    import brlm_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_DIV  = 8'b0000_0010,
        ST_SQRT = 8'b0000_0100,
        ST_LOGA = 8'b0000_1000,
        ST_LOGB = 8'b0001_0000,
        ST_MUL  = 8'b0010_0000,
        ST_DB   = 8'b0100_0000,
        ST_OUT  = 8'b1000_0000
    } bstate_t;

    bstate_t state_reg, state_next;
    logic [SUM_W-1:0] num_reg, num_next;
    logic [SUM_W-1:0] quo_reg, quo_next;
    logic [24:0] rem_reg, rem_next;
    logic [24:0] den_reg, den_next;
    logic [6:0] step_reg, step_next;
    logic [SUM_W+1:0] sn_reg, sn_next;
    logic [SUM_W+1:0] sr_reg, sr_next;
    logic [SUM_W+1:0] sb_reg, sb_next;
    logic [15:0] rms_reg, rms_next;
    logic [30:0] mant_reg, mant_next;
    logic signed [21:0] lg_reg, lg_next;
    logic signed [21:0] lgr_reg, lgr_next;
    logic signed [21:0] dd_reg, dd_next;
    logic signed [53:0] prod_reg, prod_next;
    logic cal_reg, cal_next;
    logic [15:0] ref_reg, ref_next;
    logic hasref_reg, hasref_next;
    logic [3:0] exp_sel;
    result_t out_reg, out_next;
    logic outv_reg, outv_next;

    logic [25:0] rem_sh;
    logic [61:0] msq;
    logic [4:0] lead;
    logic [15:0] log_src;
    logic signed [53:0] rnd;
    logic signed [21:0] dbw;
    logic signed [16:0] db_s, spl_w;
    logic [SUM_W+1:0] trial;

    assign req_ready = (state_reg == ST_IDLE);
    assign res_valid = outv_reg;
    assign res = out_reg;
    assign rem_sh = {rem_reg, num_reg[SUM_W-1]};
    assign msq = 62'(mant_reg) * 62'(mant_reg);
    assign trial = sr_reg + sb_reg;
    assign log_src = (step_reg[6]) ? ref_reg : rms_reg;
    assign rnd = prod_reg + (54'sd1 <<< 31);
    assign dbw = 22'(rnd >>> 32);
    assign exp_sel = 4'(lead);

    always_comb
    begin
        lead = '0;
        for (int i = 0; i < 16; i++)
            if (log_src[i]) lead = 5'(i);
    end

    always_comb
    begin
        state_next = state_reg;
        num_next = num_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        step_next = step_reg;
        sn_next = sn_reg;
        sr_next = sr_reg;
        sb_next = sb_reg;
        rms_next = rms_reg;
        mant_next = mant_reg;
        lg_next = lg_reg;
        lgr_next = lgr_reg;
        dd_next = dd_reg;
        prod_next = prod_reg;
        cal_next = cal_reg;
        ref_next = ref_reg;
        hasref_next = hasref_reg;
        out_next = out_reg;
        outv_next = outv_reg;
        db_s = '0;
        spl_w = '0;
        if (outv_reg && res_ready)
            outv_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    num_next = req.sum;
                    den_next = req.count;
                    cal_next = req.calibrate;
                    quo_next = '0;
                    rem_next = '0;
                    step_next = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                // restoring division, one quotient bit per cycle
                if (den_reg == '0)
                begin
                    quo_next = '0;
                    step_next = 7'd64;
                end
                else if (26'(rem_sh) >= 26'(den_reg))
                begin
                    rem_next = 25'(rem_sh - 26'(den_reg));
                    quo_next = {quo_reg[SUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[24:0];
                    quo_next = {quo_reg[SUM_W-2:0], 1'b0};
                end
                num_next = {num_reg[SUM_W-2:0], 1'b0};
                step_next = step_reg + 1'b1;
                if (step_reg >= 7'd63)
                begin
                    sn_next = '0;
                    sr_next = '0;
                    sb_next = 66'd1 << 64;
                    state_next = ST_SQRT;
                end
                if (den_reg == '0)
                    sn_next = '0;
                else if (step_reg >= 7'd63)
                    sn_next = {quo_next, 2'b00};
            end
            ST_SQRT:
            begin
                if (sb_reg == '0)
                begin
                    rms_next = (sr_reg > 66'd65535) ? 16'hFFFF : sr_reg[15:0];
                    step_next = '0;
                    state_next = ST_LOGA;
                end
                else
                begin
                    if (sn_reg >= trial)
                    begin
                        sn_next = sn_reg - trial;
                        sr_next = (sr_reg >> 1) + sb_reg;
                    end
                    else
                        sr_next = sr_reg >> 1;
                    sb_next = sb_reg >> 2;
                end
            end
            ST_LOGA, ST_LOGB:
            begin
                // step 0 loads, steps 1..16 square the mantissa
                if (step_reg[4:0] == 5'd0 && !step_reg[5])
                begin
                    mant_next = 31'(log_src) << (5'd30 - lead);
                    lg_next = 22'(exp_sel) <<< 16;
                    step_next = step_reg + 1'b1;
                end
                else
                begin
                    if (msq[61:30] >= 32'h8000_0000)
                    begin
                        mant_next = msq[61:31];
                        lg_next = lg_reg | (22'sd1 <<< (5'd16 - step_reg[4:0]));
                    end
                    else
                        mant_next = msq[60:30];
                    step_next = step_reg + 1'b1;
                    if (step_reg[4:0] == 5'd16)
                    begin
                        if (state_reg == ST_LOGA)
                        begin
                            lgr_next = lg_next;
                            step_next = 7'b100_0000;
                            state_next = ST_LOGB;
                        end
                        else
                            state_next = ST_MUL;
                    end
                end
                if (state_reg == ST_LOGA && rms_reg == '0)
                    state_next = ST_DB;
                if (state_reg == ST_LOGA && step_reg[4:0] == 5'd16)
                    if (!(hasref_reg && ref_reg != '0))
                        state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (step_reg[6] && hasref_reg && ref_reg != '0)
                    dd_next = lgr_reg - lg_reg;
                else
                    dd_next = lgr_reg - (22'sd16 <<< 16);
                state_next = ST_DB;
                step_next = '0;
            end
            ST_DB:
            begin
                if (step_reg == '0 && rms_reg != '0)
                begin
                    prod_next = 54'(dd_reg) * 54'(DB_PER_LOG2);
                    step_next = 7'd1;
                end
                else if (!outv_reg)
                begin
                    if (rms_reg == '0)
                    begin
                        out_next.level_db = 16'h8000;
                        out_next.level_db_spl = 16'h8000;
                    end
                    else
                    begin
                        db_s = (dbw > 22'sd32767) ? 17'sd32767 :
                               (dbw < -22'sd32768) ? -17'sd32768 : 17'(dbw);
                        spl_w = db_s + 17'(spl_offset);
                        out_next.level_db = db_s[15:0];
                        out_next.level_db_spl = (spl_w > 17'sd32767) ? 16'h7FFF :
                            (spl_w < -17'sd32768) ? 16'h8000 : spl_w[15:0];
                    end
                    out_next.rms_level = rms_reg;
                    out_next.calibration_done = cal_reg;
                    outv_next = 1'b1;
                    if (cal_reg)
                    begin
                        ref_next = rms_reg;
                        hasref_next = 1'b1;
                    end
                    state_next = ST_OUT;
                end
            end
            ST_OUT: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ref_reg <= '0;
            hasref_reg <= 1'b0;
            outv_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ref_reg <= ref_next;
            hasref_reg <= hasref_next;
            outv_reg <= outv_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        sn_reg <= sn_next;
        sr_reg <= sr_next;
        sb_reg <= sb_next;
        rms_reg <= rms_next;
        mant_reg <= mant_next;
        lg_reg <= lg_next;
        lgr_reg <= lgr_next;
        dd_reg <= dd_next;
        prod_reg <= prod_next;
        cal_reg <= cal_next;
        out_reg <= out_next;
    end

endmodule

// ===== hdl/biquad_rms_level_meter.sv =====
// biquad rms level meter
// in: sample transactions (sample, block_start, window_last, calibrate),
//   accepted on valid && ready; the filter front works out feedforward
//   products, then feedback products, and takes a new sample only once
//   through with the last; after a window end it waits for the queue
// cfg: register writes (index, data), always ready; write only when idle
// out: one result transaction per window_last sample
// the front hands the closed window's sum and count to the back end
//   through a one-entry queue; the back end runs a 64-step divider, a
//   33-step square root, a 17-step log2 pass, a second such pass when a
//   reference is stored, and a scaling multiply; a silent window skips
//   the log2 passes and the multiply
// while the back end is busy the front keeps filtering; a second window
//   end stalls the input until the queue frees
// the result sits in an output register until taken; a stalled receiver
//   holds the back end, then the queue, then the input
// reset restores the coefficients, clears the filter delays, the sum,
//   the count and the calibration reference
module biquad_rms_level_meter #(
    parameter int MAX_WINDOW_SAMPLES = 1048576
) (
    input  logic         clk,
    input  logic         rst_n,
    brlm_sample_if.sink  in_ch,
    brlm_cfg_if.sink     cfg,
    brlm_result_if.source out_ch
);
    import brlm_pkg::*;

    logic signed [31:0] feed0_reg, feed1_reg, feed2_reg, back1_reg, back2_reg;
    logic signed [15:0] offset_reg;
    win_req_t req;
    logic req_valid, req_ready;
    result_t res;

    // configuration registers, writes always taken
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            feed0_reg <= FEED0_RST;
            feed1_reg <= FEED1_RST;
            feed2_reg <= FEED2_RST;
            back1_reg <= BACK1_RST;
            back2_reg <= BACK2_RST;
            offset_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_FEED0:  feed0_reg <= cfg.data;
                REG_FEED1:  feed1_reg <= cfg.data;
                REG_FEED2:  feed2_reg <= cfg.data;
                REG_BACK1:  back1_reg <= cfg.data;
                REG_BACK2:  back2_reg <= cfg.data;
                REG_OFFSET: offset_reg <= cfg.data[15:0];
                default: ;
            endcase
        end
    end

    // filter front: biquad, squared sum and window count
    brlm_front #(
        .MAX_WINDOW_SAMPLES(MAX_WINDOW_SAMPLES)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_ch.valid),
        .in_ready(in_ch.ready),
        .sample(in_ch.sample),
        .block_start(in_ch.block_start),
        .window_last(in_ch.window_last),
        .calibrate(in_ch.calibrate),
        .feed0(feed0_reg),
        .feed1(feed1_reg),
        .feed2(feed2_reg),
        .back1(back1_reg),
        .back2(back2_reg),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req(req)
    );

    // level back end: mean, rms, log and dB
    brlm_back u_back (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req(req),
        .spl_offset(offset_reg),
        .res_valid(out_ch.valid),
        .res_ready(out_ch.ready),
        .res(res)
    );

    assign out_ch.rms_level = res.rms_level;
    assign out_ch.level_db = res.level_db;
    assign out_ch.level_db_spl = res.level_db_spl;
    assign out_ch.calibration_done = res.calibration_done;

endmodule
